// ===== hw/rtl/i2cbm_pkg.sv =====
// shared types and constants for the i2c bus monitor
`timescale 1ns / 1ps

package i2cbm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLE     = 2'd0;
  localparam logic [1:0] CFG_MASK_VALUE = 2'd1;
  localparam logic [1:0] CFG_MASK_CARE  = 2'd2;

  // bits per byte before the ack slot
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // token kinds on the output channel
  typedef enum logic [1:0] {
    TOK_START = 2'd0,
    TOK_STOP  = 2'd1,
    TOK_ADDR  = 2'd2,
    TOK_DATA  = 2'd3
  } tok_kind_e;

  // classified line event passed from front to back
  typedef struct packed {
    logic sda_fall;
    logic sda_rise;
    logic scl_rise;
    logic sda;
  } line_ev_t;

  // one result beat
  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  rx_byte;
    logic        nack;
    logic        is_read;
    logic [6:0]  bus_address;
    logic        address_match;
    logic        keep_transaction;
  } token_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== hw/rtl/i2cbm_fifo.sv =====
// small event queue between the front and back parts
`timescale 1ns / 1ps

module i2cbm_fifo #(
  parameter int Depth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  i2cbm_pkg::line_ev_t   push_data_i,
  input  logic                  pop_i,
  output i2cbm_pkg::line_ev_t   pop_data_o,
  output i2cbm_pkg::fifo_stat_t stat_o
);
  import i2cbm_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  line_ev_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage write
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/i2cbm_front.sv =====
// sample intake: line level tracking and edge classification
`timescale 1ns / 1ps

module i2cbm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  enable_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  scl_level_i,
  input  logic                  sda_level_i,
  input  i2cbm_pkg::fifo_stat_t fifo_stat_i,
  output logic                  push_o,
  output i2cbm_pkg::line_ev_t   push_data_o
);
  import i2cbm_pkg::*;

  logic prev_scl_q, prev_sda_q;
  logic accept;
  logic sda_chg;

  assign in_stall_o = fifo_stat_i.full;
  assign accept     = in_valid_i && !fifo_stat_i.full;

  // classify the sample against the previous levels
  assign sda_chg = (sda_level_i != prev_sda_q);
  assign push_data_o.sda_fall = enable_i && scl_level_i && sda_chg && !sda_level_i;
  assign push_data_o.sda_rise = enable_i && scl_level_i && sda_chg && sda_level_i;
  assign push_data_o.scl_rise = enable_i && !prev_scl_q && scl_level_i;
  assign push_data_o.sda      = sda_level_i;

  // only beats that can change decoder state go into the queue
  assign push_o = accept && (push_data_o.sda_fall || push_data_o.sda_rise ||
                             push_data_o.scl_rise);

  // previous line levels, idle bus is high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_scl_q <= 1'b1;
      prev_sda_q <= 1'b1;
    end else if (accept) begin
      prev_scl_q <= scl_level_i;
      prev_sda_q <= sda_level_i;
    end
  end

endmodule

// ===== hw/rtl/i2cbm_back.sv =====
// protocol decoder: byte assembly, address check and token output register
`timescale 1ns / 1ps

module i2cbm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic [7:0]          mask_value_i,
  input  logic [1:0]          mask_care_i,
  input  logic                ev_valid_i,
  input  i2cbm_pkg::line_ev_t ev_i,
  output logic                ev_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2cbm_pkg::token_t   token_o
);
  import i2cbm_pkg::*;

  logic       recording_q, recording_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] bit_idx_q, bit_idx_d;
  logic       expect_addr_q, expect_addr_d;
  logic       saw_byte_q, saw_byte_d;
  logic       any_match_q, any_match_d;
  logic       out_valid_q;
  token_t     token_q, tok;
  logic       emit;
  logic       take;
  logic       match;

  assign take     = !out_valid_q || !out_stall_i;
  assign ev_pop_o = ev_valid_i && take;

  // nibble care mask against the 7-bit address
  always_comb begin
    match = 1'b1;
    if (mask_care_i[0] && ({1'b0, shift_q[7:5]} != mask_value_i[7:4])) begin
      match = 1'b0;
    end
    if (mask_care_i[1] && (shift_q[4:1] != mask_value_i[3:0])) begin
      match = 1'b0;
    end
  end

  // decode one queued event: sda rule first, then the scl rule
  always_comb begin
    recording_d   = recording_q;
    shift_d       = shift_q;
    bit_idx_d     = bit_idx_q;
    expect_addr_d = expect_addr_q;
    saw_byte_d    = saw_byte_q;
    any_match_d   = any_match_q;
    emit          = 1'b0;
    tok           = '0;
    if (ev_pop_o) begin
      if (ev_i.sda_fall) begin
        if (!recording_q) begin
          recording_d = 1'b1;
          saw_byte_d  = 1'b0;
          any_match_d = 1'b0;
        end
        shift_d       = '0;
        bit_idx_d     = '0;
        expect_addr_d = 1'b1;
        emit          = 1'b1;
        tok.kind      = TOK_START;
      end else if (ev_i.sda_rise && recording_q) begin
        emit                 = 1'b1;
        tok.kind             = TOK_STOP;
        tok.keep_transaction = saw_byte_q && any_match_q;
        recording_d   = 1'b0;
        shift_d       = '0;
        bit_idx_d     = '0;
        expect_addr_d = 1'b1;
        saw_byte_d    = 1'b0;
        any_match_d   = 1'b0;
      end
      if (ev_i.scl_rise && recording_d) begin
        if (bit_idx_d < BITS_PER_BYTE) begin
          shift_d   = {shift_d[6:0], ev_i.sda};
          bit_idx_d = bit_idx_d + 4'd1;
        end else if (!emit) begin
          emit        = 1'b1;
          tok.rx_byte = shift_q;
          tok.nack    = ev_i.sda;
          if (expect_addr_q) begin
            tok.kind          = TOK_ADDR;
            tok.is_read       = shift_q[0];
            tok.bus_address   = shift_q[7:1];
            tok.address_match = match;
            expect_addr_d     = 1'b0;
            saw_byte_d        = 1'b1;
            any_match_d       = any_match_q || match;
          end else begin
            tok.kind = TOK_DATA;
          end
          shift_d   = '0;
          bit_idx_d = '0;
        end
      end
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recording_q   <= 1'b0;
      shift_q       <= '0;
      bit_idx_q     <= '0;
      expect_addr_q <= 1'b1;
      saw_byte_q    <= 1'b0;
      any_match_q   <= 1'b0;
    end else if (clear_i) begin
      recording_q   <= 1'b0;
      shift_q       <= '0;
      bit_idx_q     <= '0;
      expect_addr_q <= 1'b1;
      saw_byte_q    <= 1'b0;
      any_match_q   <= 1'b0;
    end else begin
      recording_q   <= recording_d;
      shift_q       <= shift_d;
      bit_idx_q     <= bit_idx_d;
      expect_addr_q <= expect_addr_d;
      saw_byte_q    <= saw_byte_d;
      any_match_q   <= any_match_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      token_q <= tok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign token_o     = token_q;

endmodule

// ===== hw/rtl/i2c_bus_monitor_top.sv =====
// i2c bus monitor top level: config registers, front, event queue and back
// path: a sample that ends a token is written into the event queue, then decoded into the output register
// throughput: one sample per cycle; samples are stalled only when the event queue fills
// the queue fills only while the output side holds off tokens
// reset: lines read as high, decoder idle, sniffing disabled, masks cleared
`timescale 1ns / 1ps

module i2c_bus_monitor_top #(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       scl_level_i,
  input  logic       sda_level_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] token_kind_o,
  output logic [7:0] rx_byte_o,
  output logic       nack_o,
  output logic       is_read_o,
  output logic [6:0] bus_address_o,
  output logic       address_match_o,
  output logic       keep_transaction_o
);
  import i2cbm_pkg::*;

  logic       enable_q;
  logic [7:0] mask_value_q;
  logic [1:0] mask_care_q;
  logic       clear;
  logic       push, pop;
  line_ev_t   push_ev, pop_ev;
  fifo_stat_t fifo_stat;
  token_t     token;

  // configuration registers
  assign clear = cfg_we_i && (cfg_idx_i == CFG_ENABLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      mask_value_q <= '0;
      mask_care_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE:     enable_q     <= cfg_data_i[0];
        CFG_MASK_VALUE: mask_value_q <= cfg_data_i;
        CFG_MASK_CARE:  mask_care_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // sample intake
  i2cbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (enable_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .scl_level_i (scl_level_i),
    .sda_level_i (sda_level_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_data_o (push_ev)
  );

  // event queue
  i2cbm_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_ev),
    .pop_i       (pop),
    .pop_data_o  (pop_ev),
    .stat_o      (fifo_stat)
  );

  // decoder
  i2cbm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (clear),
    .mask_value_i (mask_value_q),
    .mask_care_i  (mask_care_q),
    .ev_valid_i   (!fifo_stat.empty),
    .ev_i         (pop_ev),
    .ev_pop_o     (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_o      (token)
  );

  assign token_kind_o       = token.kind;
  assign rx_byte_o          = token.rx_byte;
  assign nack_o             = token.nack;
  assign is_read_o          = token.is_read;
  assign bus_address_o      = token.bus_address;
  assign address_match_o    = token.address_match;
  assign keep_transaction_o = token.keep_transaction;

  // checks
  a_keep_only_on_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && keep_transaction_o |-> token_kind_o == TOK_STOP)
    else $error("keep flag on a token that is not a stop");

  a_bus_tokens_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == TOK_START || token_kind_o == TOK_STOP)
    |-> rx_byte_o == '0 && bus_address_o == '0 && !nack_o && !address_match_o)
    else $error("start or stop token carries byte fields");

  a_addr_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == TOK_ADDR
    |-> bus_address_o == rx_byte_o[7:1] && is_read_o == rx_byte_o[0])
    else $error("address token fields disagree with the byte");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_stat.full)
    else $error("event pushed into a full queue");

endmodule

// ===== sim/i2c_bus_monitor_top_test.sv =====
// self-checking testbench for the i2c bus monitor top level
`timescale 1ns / 1ps

module i2c_bus_monitor_top_test;
  import i2cbm_pkg::*;

  // register index that decodes to nothing
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 10;
  localparam int PHASE_SAMPLES = 110;
  localparam int OFF_SAMPLES   = 40;
  localparam int RUN_LIMIT_NS  = 4000000;

  // one row of the directed plan: a line sample or a register write
  typedef enum logic {ROW_LINE, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e  what;
    logic       scl;
    logic       sda;
    logic [1:0] idx;
    logic [7:0] data;
    logic       pinned;
    token_t     tok;
  } plan_row_t;

  // tokens that can be read straight off the bus sequence
  localparam token_t T_START = '{TOK_START, 8'h00, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0};
  localparam token_t T_ADDR_TOP = '{TOK_ADDR, 8'hFF, 1'b1, 1'b1, 7'h7F, 1'b1, 1'b0};
  localparam token_t T_STOP_KEEP = '{TOK_STOP, 8'h00, 1'b0, 1'b0, 7'h00, 1'b0, 1'b1};

  function automatic plan_row_t line_row(input logic scl, input logic sda);
    return '{ROW_LINE, scl, sda, 2'd0, 8'h00, 1'b0, token_t'('0)};
  endfunction

  function automatic plan_row_t pin_row(input logic scl, input logic sda, input token_t tok);
    return '{ROW_LINE, scl, sda, 2'd0, 8'h00, 1'b1, tok};
  endfunction

  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [7:0] data);
    return '{ROW_REG, 1'b1, 1'b1, idx, data, 1'b0, token_t'('0)};
  endfunction

  // disabled lines, idle sda rise, start, address 0xff with nack,
  // repeated start on a two-line change, then a stop that keeps the transfer
  localparam int PLAN_ROWS = 32;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    line_row(1'b1, 1'b0), line_row(1'b1, 1'b1),
    reg_row(CFG_ENABLE, 8'h01), reg_row(CFG_MASK_VALUE, 8'h7F),
    reg_row(CFG_MASK_CARE, 8'h03),
    line_row(1'b0, 1'b0), line_row(1'b1, 1'b0), line_row(1'b1, 1'b1),
    pin_row(1'b1, 1'b0, T_START),
    line_row(1'b0, 1'b1), line_row(1'b1, 1'b1), line_row(1'b0, 1'b1), line_row(1'b1, 1'b1),
    line_row(1'b0, 1'b1), line_row(1'b1, 1'b1), line_row(1'b0, 1'b1), line_row(1'b1, 1'b1),
    line_row(1'b0, 1'b1), line_row(1'b1, 1'b1), line_row(1'b0, 1'b1), line_row(1'b1, 1'b1),
    line_row(1'b0, 1'b1), line_row(1'b1, 1'b1), line_row(1'b0, 1'b1), line_row(1'b1, 1'b1),
    line_row(1'b0, 1'b1), pin_row(1'b1, 1'b1, T_ADDR_TOP),
    line_row(1'b0, 1'b1), pin_row(1'b1, 1'b0, T_START),
    line_row(1'b0, 1'b0), line_row(1'b1, 1'b0), pin_row(1'b1, 1'b1, T_STOP_KEEP)
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       scl_level_i;
  logic       sda_level_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] token_kind_o;
  logic [7:0] rx_byte_o;
  logic       nack_o;
  logic       is_read_o;
  logic [6:0] bus_address_o;
  logic       address_match_o;
  logic       keep_transaction_o;

  // pinned expectation travels with the sample beat
  logic       row_pin;
  token_t     row_pin_tok;

  i2c_bus_monitor_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .scl_level_i        (scl_level_i),
    .sda_level_i        (sda_level_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .token_kind_o       (token_kind_o),
    .rx_byte_o          (rx_byte_o),
    .nack_o             (nack_o),
    .is_read_o          (is_read_o),
    .bus_address_o      (bus_address_o),
    .address_match_o    (address_match_o),
    .keep_transaction_o (keep_transaction_o)
  );

  always #10 clk_i = ~clk_i;

  // decoder mirror state
  logic       line_scl  = 1'b1;
  logic       line_sda  = 1'b1;
  logic       in_frame  = 1'b0;
  logic [7:0] shreg     = 8'h00;
  logic [3:0] bit_cnt   = 4'd0;
  logic       want_addr = 1'b1;
  logic       seen_addr = 1'b0;
  logic       any_hit   = 1'b0;
  logic       reg_en    = 1'b0;
  logic [7:0] reg_mask  = 8'h00;
  logic [1:0] reg_care  = 2'd0;

  token_t bus_tokens_due [$];
  token_t next_tok;
  bit     have_tok;

  int bad_count;
  int samples_taken;
  int held_samples;
  int reg_writes;
  int kind_seen [4];

  // driver bookkeeping
  logic       cur_scl = 1'b1;
  logic       cur_sda = 1'b1;
  logic [7:0] drv_mask = 8'h00;
  int         burst_left;
  int         sent_count;
  bit         hold_req;

  function automatic void clear_frame();
    in_frame  = 1'b0;
    shreg     = 8'h00;
    bit_cnt   = 4'd0;
    want_addr = 1'b1;
    seen_addr = 1'b0;
    any_hit   = 1'b0;
  endfunction

  function automatic void load_register(input logic [1:0] idx, input logic [7:0] data);
    case (idx)
      CFG_ENABLE: begin
        reg_en = data[0];
        clear_frame();
      end
      CFG_MASK_VALUE: reg_mask = data;
      CFG_MASK_CARE:  reg_care = data[1:0];
      default: ;
    endcase
  endfunction

  // one line sample through the decoder, returns 1 when a token comes out
  function automatic bit decode_line_sample(input logic scl, input logic sda,
                                            output token_t tok);
    bit         emitted;
    logic       was;
    logic [6:0] adr;
    logic       hit;
    emitted = 1'b0;
    tok     = '0;
    // data line rule, judged with the new clock level
    if (sda != line_sda) begin
      was      = line_sda;
      line_sda = sda;
      if (reg_en && scl) begin
        if (was && !sda) begin
          if (!in_frame) begin
            in_frame  = 1'b1;
            seen_addr = 1'b0;
            any_hit   = 1'b0;
          end
          shreg     = 8'h00;
          bit_cnt   = 4'd0;
          want_addr = 1'b1;
          tok.kind  = TOK_START;
          emitted   = 1'b1;
        end else if (!was && sda && in_frame) begin
          tok.kind             = TOK_STOP;
          tok.keep_transaction = seen_addr & any_hit;
          emitted              = 1'b1;
          clear_frame();
        end
      end
    end
    // clock line rule: shift on rise, ninth rise closes the byte
    if (scl != line_scl) begin
      was      = line_scl;
      line_scl = scl;
      if (!was && scl && in_frame && reg_en) begin
        if (bit_cnt < BITS_PER_BYTE) begin
          shreg   = {shreg[6:0], sda};
          bit_cnt = bit_cnt + 4'd1;
        end else if (!emitted) begin
          tok.rx_byte = shreg;
          tok.nack    = sda;
          if (want_addr) begin
            adr = shreg[7:1];
            hit = (!reg_care[0] || {1'b0, adr[6:4]} == reg_mask[7:4]) &&
                  (!reg_care[1] || adr[3:0] == reg_mask[3:0]);
            tok.kind          = TOK_ADDR;
            tok.is_read       = shreg[0];
            tok.bus_address   = adr;
            tok.address_match = hit;
            want_addr         = 1'b0;
            seen_addr         = 1'b1;
            any_hit           = any_hit | hit;
          end else begin
            tok.kind = TOK_DATA;
          end
          emitted = 1'b1;
          shreg   = 8'h00;
          bit_cnt = 4'd0;
        end
      end
    end
    return emitted;
  endfunction

  function automatic void note_bad(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("@%0t bad token: %s", $time, msg);
  endfunction

  function automatic void check_token();
    token_t want;
    kind_seen[token_kind_o]++;
    if (bus_tokens_due.size() == 0) begin
      note_bad($sformatf("none due, got kind %0d byte %02h", token_kind_o, rx_byte_o));
      return;
    end
    want = bus_tokens_due.pop_front();
    if (token_kind_o !== want.kind || rx_byte_o !== want.rx_byte ||
        nack_o !== want.nack || is_read_o !== want.is_read ||
        bus_address_o !== want.bus_address || address_match_o !== want.address_match ||
        keep_transaction_o !== want.keep_transaction)
      note_bad($sformatf({"want kind %0d byte %02h nack %0d rd %0d adr %02h hit %0d keep %0d,",
                          " got kind %0d byte %02h nack %0d rd %0d adr %02h hit %0d keep %0d"},
                         want.kind, want.rx_byte, want.nack, want.is_read,
                         want.bus_address, want.address_match, want.keep_transaction,
                         token_kind_o, rx_byte_o, nack_o, is_read_o,
                         bus_address_o, address_match_o, keep_transaction_o));
  endfunction

  // watch both channels and the register port at every edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) load_register(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_stall_o) held_samples++;
      if (in_valid_i && !in_stall_o) begin
        samples_taken++;
        have_tok = decode_line_sample(scl_level_i, sda_level_i, next_tok);
        if (row_pin) bus_tokens_due.push_back(row_pin_tok);
        else if (have_tok) bus_tokens_due.push_back(next_tok);
      end
      if (out_valid_o && !out_stall_i) check_token();
    end
  end

  // offer one sample beat, in bursts with random gaps
  task automatic send_line(input logic scl, input logic sda, input logic pinned = 1'b0,
                           input token_t pin_tok = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    scl_level_i <= scl;
    sda_level_i <= sda;
    row_pin     <= pinned;
    row_pin_tok <= pin_tok;
    do @(posedge clk_i); while (in_stall_o);
    cur_scl = scl;
    cur_sda = sda;
    sent_count++;
  endtask

  // stop offering and let every due token come out
  task automatic quiesce();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (bus_tokens_due.size() != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_MASK_VALUE) drv_mask = data;
    reg_writes++;
  endtask

  task automatic send_bit(input logic v);
    // data wiggles while the clock is low
    if ($urandom_range(0, 5) == 0) send_line(1'b0, ~v);
    send_line(1'b0, v);
    send_line(1'b1, v);
    // clock held high for an extra sample
    if ($urandom_range(0, 7) == 0) send_line(1'b1, v);
  endtask

  task automatic clock_out_byte(input logic [7:0] val, input logic ack_bit);
    for (int k = 7; k >= 0; k--) send_bit(val[k]);
    send_bit(ack_bit);
  endtask

  function automatic logic [7:0] pick_address();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2, 3: return {drv_mask[6:0], 1'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_stop();
    send_line(1'b0, 1'b0);
    send_line(1'b1, 1'b0);
    send_line(1'b1, 1'b1);
  endtask

  // start, address, data, maybe repeated starts, then an ending of some kind
  task automatic send_transfer();
    int   nbytes;
    int   ending;
    logic addr_next;
    // bring the bus to idle without making a start
    if (!(cur_scl && cur_sda)) begin
      if (cur_scl) send_line(1'b0, cur_sda);
      send_line(1'b0, 1'b1);
      send_line(1'b1, 1'b1);
    end
    send_line(1'b1, 1'b0);
    nbytes    = $urandom_range(1, 4);
    addr_next = 1'b1;
    for (int i = 0; i < nbytes; i++) begin
      clock_out_byte(addr_next ? pick_address() : pick_data(), $urandom_range(0, 3) == 0);
      addr_next = 1'b0;
      // repeated start, sometimes with both lines moving at once
      if ($urandom_range(0, 5) == 0) begin
        send_line(1'b0, 1'b1);
        if ($urandom_range(0, 1) == 1) send_line(1'b1, 1'b1);
        send_line(1'b1, 1'b0);
        addr_next = 1'b1;
      end
    end
    ending = $urandom_range(0, 9);
    if (ending < 8) begin
      send_stop();
    end else if (ending == 9) begin
      // byte cut short
      for (int k = $urandom_range(1, 7); k > 0; k--) send_bit(1'($urandom));
      send_stop();
    end
  endtask

  task automatic send_noise(input int count);
    for (int k = 0; k < count; k++) send_line(1'($urandom), 1'($urandom));
  endtask

  // main stimulus
  initial begin
    logic [7:0] mask_v;
    logic [1:0] care_v;
    logic       en_v;
    int         target;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_ENABLE;
    cfg_data_i  <= 8'h00;
    in_valid_i  <= 1'b0;
    scl_level_i <= 1'b1;
    sda_level_i <= 1'b1;
    row_pin     <= 1'b0;
    row_pin_tok <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed plan
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (DIRECTED_PLAN[r].what == ROW_REG) begin
        if (r == 0 || DIRECTED_PLAN[r - 1].what != ROW_REG) quiesce();
        reg_write(DIRECTED_PLAN[r].idx, DIRECTED_PLAN[r].data);
      end else begin
        send_line(DIRECTED_PLAN[r].scl, DIRECTED_PLAN[r].sda,
                  DIRECTED_PLAN[r].pinned, DIRECTED_PLAN[r].tok);
      end
    end

    // random traffic under a series of register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      mask_v = 8'($urandom);
      care_v = 2'($urandom);
      en_v   = 1'b1;
      case (ph)
        0: begin
          mask_v = 8'h00;
          care_v = 2'd0;
        end
        1: begin
          mask_v = 8'hFF;
          care_v = 2'd3;
        end
        2: en_v = 1'b0;
        3: care_v = 2'd1;
        4: care_v = 2'd2;
        default: ;
      endcase
      quiesce();
      reg_write(CFG_MASK_VALUE, mask_v);
      reg_write(CFG_MASK_CARE, {6'($urandom), care_v});
      if (ph == 4) reg_write(CFG_SPARE, 8'($urandom));
      reg_write(CFG_ENABLE, {7'($urandom), en_v});
      // long output hold-off so the event queue fills and stalls the input
      if (ph == 3) hold_req = 1'b1;
      target = sent_count + (en_v ? PHASE_SAMPLES : OFF_SAMPLES);
      while (sent_count < target) begin
        if ($urandom_range(0, 9) < 8) send_transfer();
        else send_noise($urandom_range(1, 12));
      end
    end

    quiesce();
    if (bus_tokens_due.size() != 0)
      note_bad($sformatf("%0d tokens never came out", bus_tokens_due.size()));
    $display("covered %0d bus samples under %0d settings with %0d register writes",
             samples_taken, PHASES + 1, reg_writes);
    $display("tokens seen: %0d start, %0d stop, %0d address, %0d data; input held %0d cycles",
             kind_seen[TOK_START], kind_seen[TOK_STOP], kind_seen[TOK_ADDR],
             kind_seen[TOK_DATA], held_samples);
    if (bad_count == 0) begin
      $display("i2c_bus_monitor_top: match");
    end else begin
      $display("i2c_bus_monitor_top: mismatch");
    end
    $finish;
  end

  // output side: runs of stall patterns, plus one long hold-off on request
  initial begin
    int mode;
    int run_len;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(posedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      mode    = $urandom_range(0, 3);
      run_len = $urandom_range(4, 60);
      for (int k = 0; k < run_len; k++) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= (k % 4 == 1);
          default: out_stall_i <= 1'($urandom);
        endcase
      end
    end
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("i2c_bus_monitor_top: mismatch");
    $finish;
  end

endmodule
